### rtl/bmhq_pkg.sv
// Package: heap geometry, entry and word types, command and status codes.
`timescale 1ns / 1ps
`default_nettype none
package bmhq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic       CMD_INSERT = 1'b0;
    localparam logic       CMD_DELETE = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [7:0]  row;
        logic [7:0]  col;
        logic [23:0] cost;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic        cmd;
        logic [7:0]  in_row;
        logic [7:0]  in_col;
        logic [23:0] in_cost;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [7:0]       out_row;
        logic [7:0]       out_col;
        logic [23:0]      out_cost;
        logic [CNT_W-1:0] entries_held;
    } rsp_t;

endpackage
`default_nettype wire

### rtl/bmhq_ram.sv
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module bmhq_ram #(
    parameter int   WIDTH = 40,
    parameter int   DEPTH = 1024,
    localparam int  AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

### rtl/binary_min_heap_queue_top.sv
// Min-heap priority queue: sequencer around one heap RAM.
// Overflow, underflow and an insert into an empty heap go straight to the result;
// insert otherwise does one read-compare-write per sift-up level, and a root write if it climbs there;
// delete otherwise reads root and last entry, then sifts down one level per cycle on both ports.
// One word in work at a time: the next is taken after the result loads, later if stalled.
// Reset empties the queue (count to zero); heap RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module binary_min_heap_queue_top (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire bmhq_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output bmhq_pkg::rsp_t     rsp
);
    import bmhq_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_INS_CMP  = 6'b000010,
        S_INS_FIN  = 6'b000100,
        S_DEL_RD   = 6'b001000,
        S_DEL_SIFT = 6'b010000,
        S_DONE     = 6'b100000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    entry_t           node_reg, node_next;
    entry_t           got_reg, got_next;
    logic [1:0]       status_reg, status_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic              we;
    logic [ADDR_W-1:0] waddr, raddr_a, raddr_b;
    entry_t            wdata, rdata_a, rdata_b;

    logic [CNT_W:0]   left, right, ch, ch2;
    logic [CNT_W-1:0] n_ins, par;
    logic             has_left, has_right, take_right, stop;
    entry_t           chd;
    logic             accept;

    bmhq_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(CAPACITY)
    ) u_heap (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .raddr_b(raddr_b),
        .rdata_a(rdata_a),
        .rdata_b(rdata_b)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // child selection for sift-down (count_reg already holds the reduced count), insert slot and parent
    always_comb
    begin
        left       = {pos_reg, 1'b0};
        right      = left + 1'b1;
        has_left   = (left <= {1'b0, count_reg});
        has_right  = (right <= {1'b0, count_reg});
        take_right = has_right && (rdata_a.cost > rdata_b.cost);
        ch         = take_right ? right : left;
        chd        = take_right ? rdata_b : rdata_a;
        stop       = !has_left || (chd.cost > node_reg.cost);
        ch2        = {ch[CNT_W-1:0], 1'b0};
        n_ins      = count_reg + 1'b1;
        par        = pos_reg >> 1;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        node_next      = node_reg;
        got_next       = got_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        we             = 1'b0;
        waddr          = '0;
        wdata          = node_reg;
        raddr_a        = '0;
        raddr_b        = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    got_next    = '0;
                    status_next = ST_OK;
                    if (req.cmd == CMD_INSERT)
                    begin
                        node_next = '{row: req.in_row, col: req.in_col, cost: req.in_cost};
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            status_next = ST_OVERFLOW;
                            state_next  = S_DONE;
                        end
                        else if (count_reg == '0)
                        begin
                            count_next = n_ins;
                            we         = 1'b1;
                            waddr      = '0;
                            wdata      = node_next;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            count_next = n_ins;
                            pos_next   = n_ins;
                            raddr_a    = ADDR_W'((n_ins >> 1) - 1'b1);
                            state_next = S_INS_CMP;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            raddr_a    = '0;
                            raddr_b    = ADDR_W'(count_reg - 1'b1);
                            count_next = count_reg - 1'b1;
                            state_next = S_DEL_RD;
                        end
                    end
                end
            end

            S_INS_CMP:
            begin
                we = 1'b1;
                waddr = ADDR_W'(pos_reg - 1'b1);
                if (rdata_a.cost > node_reg.cost)
                begin
                    // move parent down, climb one level
                    wdata    = rdata_a;
                    pos_next = par;
                    if (par > CNT_W'(1))
                    begin
                        raddr_a = ADDR_W'((par >> 1) - 1'b1);
                    end
                    else
                    begin
                        state_next = S_INS_FIN;
                    end
                end
                else
                begin
                    wdata      = node_reg;
                    state_next = S_DONE;
                end
            end

            S_INS_FIN:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = node_reg;
                state_next = S_DONE;
            end

            S_DEL_RD:
            begin
                got_next   = rdata_a;
                node_next  = rdata_b;
                pos_next   = CNT_W'(1);
                raddr_a    = ADDR_W'(1);
                raddr_b    = ADDR_W'(2);
                state_next = S_DEL_SIFT;
            end

            S_DEL_SIFT:
            begin
                we    = 1'b1;
                waddr = ADDR_W'(pos_reg - 1'b1);
                if (stop)
                begin
                    wdata      = node_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    // promote the smaller child, fetch its children
                    wdata    = chd;
                    pos_next = ch[CNT_W-1:0];
                    raddr_a  = ADDR_W'(ch2 - 1'b1);
                    raddr_b  = ch2[ADDR_W-1:0];
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status       = status_reg;
                    rsp_next.out_row      = got_reg.row;
                    rsp_next.out_col      = got_reg.col;
                    rsp_next.out_cost     = got_reg.cost;
                    rsp_next.entries_held = count_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        node_reg   <= node_next;
        got_reg    <= got_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

endmodule
`default_nettype wire
